// ----- src/ttb_pkg.sv -----
package ttb_pkg;

	// Status of the triangle queue, seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} ttb_fifo_stat_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SUB,
		BK_DIV,
		BK_RND,
		BK_DONE
	} ttb_back_state_t;

	// Job index: six vector components, then the determinant.
	localparam int unsigned JOB_W = 3;
	localparam logic [JOB_W-1:0] JOB_TAN_X = 3'd0;
	localparam logic [JOB_W-1:0] JOB_TAN_Y = 3'd1;
	localparam logic [JOB_W-1:0] JOB_TAN_Z = 3'd2;
	localparam logic [JOB_W-1:0] JOB_BIT_X = 3'd3;
	localparam logic [JOB_W-1:0] JOB_BIT_Y = 3'd4;
	localparam logic [JOB_W-1:0] JOB_BIT_Z = 3'd5;
	localparam logic [JOB_W-1:0] JOB_DET = 3'd6;

	localparam int unsigned NUM_COMP = 6;

endpackage

// ----- src/ttb_fifo.sv -----
module ttb_fifo
	import ttb_pkg::*;
#(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output ttb_fifo_stat_t   stat
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	// Two-entry storage; the oldest entry is always presented.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = count_q[1];
	assign stat.empty = (count_q == 2'd0);

endmodule

// ----- src/ttb_front.sv -----
module ttb_front
	import ttb_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 16,
	parameter int unsigned UV_WIDTH    = 16,
	localparam int unsigned DW         = COORD_WIDTH + 1,
	localparam int unsigned UW         = UV_WIDTH + 1,
	localparam int unsigned REC_W      = 6 * DW + 4 * UW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [UV_WIDTH-1:0]    tex_u,
	input  logic signed [UV_WIDTH-1:0]    tex_v,
	input  ttb_fifo_stat_t                q_stat,
	output logic                          q_wr,
	output logic [REC_W-1:0]              q_data
);

	logic [1:0]                    corner_q;
	logic signed [COORD_WIDTH-1:0] hpx_q [2];
	logic signed [COORD_WIDTH-1:0] hpy_q [2];
	logic signed [COORD_WIDTH-1:0] hpz_q [2];
	logic signed [UV_WIDTH-1:0]    hu_q  [2];
	logic signed [UV_WIDTH-1:0]    hv_q  [2];
	logic                          accept;
	logic                          third;
	logic signed [DW-1:0]          e0x, e0y, e0z, e1x, e1y, e1z;
	logic signed [UW-1:0]          du0, dv0, du1, dv1;

	// Only the closing corner needs room in the queue.
	assign third  = (corner_q == 2'd2);
	assign full   = third & q_stat.full;
	assign accept = push & ~full;
	assign q_wr   = accept & third;

	// Corner counter: 0, 1, 2 and back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= 2'd0;
		end else if (accept) begin
			corner_q <= third ? 2'd0 : corner_q + 2'd1;
		end
	end

	// Hold the first two corners of the triangle.
	always_ff @(posedge clk) begin
		if (accept && !third) begin
			hpx_q[corner_q[0]] <= pos_x;
			hpy_q[corner_q[0]] <= pos_y;
			hpz_q[corner_q[0]] <= pos_z;
			hu_q[corner_q[0]]  <= tex_u;
			hv_q[corner_q[0]]  <= tex_v;
		end
	end

	// Edges and texture deltas of the completed triangle.
	always_comb begin
		e0x = DW'(hpx_q[1]) - DW'(hpx_q[0]);
		e0y = DW'(hpy_q[1]) - DW'(hpy_q[0]);
		e0z = DW'(hpz_q[1]) - DW'(hpz_q[0]);
		e1x = DW'(pos_x) - DW'(hpx_q[0]);
		e1y = DW'(pos_y) - DW'(hpy_q[0]);
		e1z = DW'(pos_z) - DW'(hpz_q[0]);
		du0 = UW'(hu_q[1]) - UW'(hu_q[0]);
		dv0 = UW'(hv_q[1]) - UW'(hv_q[0]);
		du1 = UW'(tex_u) - UW'(hu_q[0]);
		dv1 = UW'(tex_v) - UW'(hv_q[0]);
	end

	assign q_data = {e0x, e0y, e0z, e1x, e1y, e1z, du0, dv0, du1, dv1};

endmodule

// ----- src/ttb_back.sv -----
module ttb_back
	import ttb_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 16,
	parameter int unsigned UV_WIDTH    = 16,
	parameter int unsigned OUT_WIDTH   = 32,
	localparam int unsigned DW         = COORD_WIDTH + 1,
	localparam int unsigned UW         = UV_WIDTH + 1,
	localparam int unsigned REC_W      = 6 * DW + 4 * UW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ttb_fifo_stat_t              q_stat,
	input  logic [REC_W-1:0]            q_data,
	output logic                        q_rd,
	input  logic                        pop,
	output logic                        empty,
	output logic signed [OUT_WIDTH-1:0] tangent_x,
	output logic signed [OUT_WIDTH-1:0] tangent_y,
	output logic signed [OUT_WIDTH-1:0] tangent_z,
	output logic signed [OUT_WIDTH-1:0] bitangent_x,
	output logic signed [OUT_WIDTH-1:0] bitangent_y,
	output logic signed [OUT_WIDTH-1:0] bitangent_z,
	output logic                        degenerate,
	output logic                        saturated
);

	localparam int unsigned MW  = (DW > UW) ? DW : UW;
	localparam int unsigned PW  = 2 * MW;
	localparam int unsigned XW  = PW + 1;
	localparam int          SH  = int'(OUT_WIDTH / 2) + int'(UV_WIDTH) - 3
		- int'(COORD_WIDTH / 2);
	localparam int unsigned SHN = (SH > 0) ? SH : 0;
	localparam int unsigned SHD = (SH < 0) ? -SH : 0;
	localparam int unsigned NW  = XW + SHN;
	localparam int unsigned DMW = XW + SHD;
	localparam int unsigned RW  = DMW + 1;
	localparam int unsigned QW  = NW + 1;
	localparam int unsigned CW  = ((QW > OUT_WIDTH) ? QW : OUT_WIDTH) + 1;
	localparam int unsigned CNW = $clog2(NW + 1);

	ttb_back_state_t       state_q, state_d;
	logic [REC_W-1:0]      rec_q;
	logic [JOB_W-1:0]      job_q;
	logic signed [PW-1:0]  prod_a_s1, prod_b_s1;
	logic [NW-1:0]         num_q;
	logic [RW-1:0]         rem_q;
	logic [NW-1:0]         quo_q;
	logic [CNW-1:0]        cnt_q;
	logic [DMW-1:0]        dmag_q;
	logic                  det_neg_q;
	logic                  neg_q;
	logic                  sat_acc_q;
	logic                  degen_q;
	logic [OUT_WIDTH-1:0]  comp_q [NUM_COMP];
	logic [OUT_WIDTH-1:0]  res_q  [NUM_COMP];
	logic                  res_deg_q;
	logic                  res_sat_q;
	logic                  res_valid_q;

	logic signed [DW-1:0]  e0x, e0y, e0z, e1x, e1y, e1z, e0k, e1k;
	logic signed [UW-1:0]  du0, dv0, du1, dv1;
	logic signed [MW-1:0]  op_a, op_b, op_c, op_d;
	logic signed [XW-1:0]  diff;
	logic [XW-1:0]         diff_mag;
	logic [RW-1:0]         rsh;
	logic                  rge;
	logic                  rnd_up;
	logic [CW-1:0]         qx, lim, val_w;
	logic                  clip;
	logic                  slot_free;
	logic                  load_job, do_sub, do_div, do_rnd, do_out;

	assign {e0x, e0y, e0z, e1x, e1y, e1z, du0, dv0, du1, dv1} = rec_q;

	// Operand selection: det = du0*dv1 - du1*dv0,
	// tangent = e0*dv1 - e1*dv0, bitangent = e1*du0 - e0*du1.
	always_comb begin
		e0k = e0x;
		e1k = e1x;
		case (job_q)
			JOB_TAN_Y, JOB_BIT_Y: begin
				e0k = e0y;
				e1k = e1y;
			end
			JOB_TAN_Z, JOB_BIT_Z: begin
				e0k = e0z;
				e1k = e1z;
			end
			default: begin
				e0k = e0x;
				e1k = e1x;
			end
		endcase
		case (job_q)
			JOB_DET: begin
				op_a = MW'(du0);
				op_b = MW'(dv1);
				op_c = MW'(du1);
				op_d = MW'(dv0);
			end
			JOB_TAN_X, JOB_TAN_Y, JOB_TAN_Z: begin
				op_a = MW'(e0k);
				op_b = MW'(dv1);
				op_c = MW'(e1k);
				op_d = MW'(dv0);
			end
			default: begin
				op_a = MW'(e1k);
				op_b = MW'(du0);
				op_c = MW'(e0k);
				op_d = MW'(du1);
			end
		endcase
	end

	// Difference of the two registered products and its magnitude.
	assign diff     = XW'(prod_a_s1) - XW'(prod_b_s1);
	assign diff_mag = diff[XW-1] ? (~diff + XW'(1)) : diff;

	// One restoring division step.
	assign rsh = {rem_q[RW-2:0], num_q[NW-1]};
	assign rge = (rsh >= RW'(dmag_q));

	// Rounding to nearest, ties away from zero, then clipping.
	always_comb begin
		rnd_up = ({rem_q, 1'b0} >= (RW + 1)'(dmag_q));
		qx     = CW'(quo_q) + CW'(rnd_up);
		lim    = CW'(1) << (OUT_WIDTH - 1);
		if (neg_q) begin
			clip  = (qx > lim);
			val_w = clip ? lim : (~qx + CW'(1));
		end else begin
			clip  = (qx > (lim - CW'(1)));
			val_w = clip ? (lim - CW'(1)) : qx;
		end
	end

	assign slot_free = ~res_valid_q | pop;

	// Sequencer: determinant first, then the six components unless it is zero.
	always_comb begin
		state_d  = state_q;
		q_rd     = 1'b0;
		load_job = 1'b0;
		do_sub   = 1'b0;
		do_div   = 1'b0;
		do_rnd   = 1'b0;
		do_out   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					q_rd    = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_SUB;
			end
			BK_SUB: begin
				do_sub = 1'b1;
				if (job_q == JOB_DET && diff == '0) begin
					state_d = BK_DONE;
				end else if (job_q == JOB_DET) begin
					state_d = BK_MUL;
				end else begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				do_div = 1'b1;
				if (cnt_q == CNW'(1)) begin
					state_d = BK_RND;
				end
			end
			BK_RND: begin
				do_rnd = 1'b1;
				state_d = (job_q == JOB_BIT_Z) ? BK_DONE : BK_MUL;
			end
			BK_DONE: begin
				if (slot_free) begin
					do_out  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		load_job = q_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Job index is control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= JOB_DET;
		end else if (load_job) begin
			job_q <= JOB_DET;
		end else if (do_sub && job_q == JOB_DET) begin
			job_q <= JOB_TAN_X;
		end else if (do_rnd) begin
			job_q <= job_q + JOB_W'(1);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (load_job) begin
			rec_q     <= q_data;
			sat_acc_q <= 1'b0;
			degen_q   <= 1'b0;
		end
		prod_a_s1 <= op_a * op_b;
		prod_b_s1 <= op_c * op_d;
		if (do_sub) begin
			if (job_q == JOB_DET) begin
				dmag_q    <= DMW'(diff_mag) << SHD;
				det_neg_q <= diff[XW-1];
				if (diff == '0) begin
					degen_q <= 1'b1;
					for (int i = 0; i < NUM_COMP; i++) begin
						comp_q[i] <= '0;
					end
				end
			end else begin
				num_q <= NW'(diff_mag) << SHN;
				neg_q <= diff[XW-1] ^ det_neg_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CNW'(NW);
			end
		end
		if (do_div) begin
			num_q <= num_q << 1;
			rem_q <= rge ? (rsh - RW'(dmag_q)) : rsh;
			quo_q <= {quo_q[NW-2:0], rge};
			cnt_q <= cnt_q - CNW'(1);
		end
		if (do_rnd) begin
			comp_q[job_q] <= val_w[OUT_WIDTH-1:0];
			sat_acc_q     <= sat_acc_q | clip;
		end
		if (do_out) begin
			res_q     <= comp_q;
			res_deg_q <= degen_q;
			res_sat_q <= sat_acc_q;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (do_out) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	assign empty       = ~res_valid_q;
	assign tangent_x   = res_q[JOB_TAN_X];
	assign tangent_y   = res_q[JOB_TAN_Y];
	assign tangent_z   = res_q[JOB_TAN_Z];
	assign bitangent_x = res_q[JOB_BIT_X];
	assign bitangent_y = res_q[JOB_BIT_Y];
	assign bitangent_z = res_q[JOB_BIT_Z];
	assign degenerate  = res_deg_q;
	assign saturated   = res_sat_q;

endmodule

// ----- src/triangle_tangent_bitangent_top.sv -----
// Channel   Handshake          Payload
// corner    push / full        pos_x, pos_y, pos_z, tex_u, tex_v
// result    empty / pop        tangent_x/y/z, bitangent_x/y/z, degenerate, saturated
//
// Corners are taken one per cycle while full is low; every third corner closes a
// triangle and enters a two-entry queue. The back end works on one triangle at a
// time: the determinant first, then each component through a bit-serial divider
// over the numerator width (56 bits at default widths).
// Reset clears the corner count, the queue and the result valid flag.
// full rises only on a closing corner while the queue is full; a waiting
// result does not block the back end until its next result is finished.
module triangle_tangent_bitangent_top
	import ttb_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 16,
	parameter int unsigned UV_WIDTH    = 16,
	parameter int unsigned OUT_WIDTH   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [UV_WIDTH-1:0]    tex_u,
	input  logic signed [UV_WIDTH-1:0]    tex_v,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [OUT_WIDTH-1:0]   tangent_x,
	output logic signed [OUT_WIDTH-1:0]   tangent_y,
	output logic signed [OUT_WIDTH-1:0]   tangent_z,
	output logic signed [OUT_WIDTH-1:0]   bitangent_x,
	output logic signed [OUT_WIDTH-1:0]   bitangent_y,
	output logic signed [OUT_WIDTH-1:0]   bitangent_z,
	output logic                          degenerate,
	output logic                          saturated
);

	localparam int unsigned REC_W = 6 * (COORD_WIDTH + 1) + 4 * (UV_WIDTH + 1);

	ttb_fifo_stat_t   q_stat;
	logic             q_wr;
	logic             q_rd;
	logic [REC_W-1:0] q_wdata;
	logic [REC_W-1:0] q_rdata;

	// Corner intake and edge forming.
	ttb_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.UV_WIDTH   (UV_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.pos_x (pos_x),
		.pos_y (pos_y),
		.pos_z (pos_z),
		.tex_u (tex_u),
		.tex_v (tex_v),
		.q_stat(q_stat),
		.q_wr  (q_wr),
		.q_data(q_wdata)
	);

	// Triangle queue between the two halves.
	ttb_fifo #(
		.WIDTH(REC_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_data(q_wdata),
		.rd_en  (q_rd),
		.rd_data(q_rdata),
		.stat   (q_stat)
	);

	// Determinant, products and division.
	ttb_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.UV_WIDTH   (UV_WIDTH),
		.OUT_WIDTH  (OUT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_data     (q_rdata),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.tangent_x  (tangent_x),
		.tangent_y  (tangent_y),
		.tangent_z  (tangent_z),
		.bitangent_x(bitangent_x),
		.bitangent_y(bitangent_y),
		.bitangent_z(bitangent_z),
		.degenerate (degenerate),
		.saturated  (saturated)
	);

`ifndef NO_ASSERTIONS
	// A degenerate triangle never reports clipping.
	a_deg_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && degenerate) |-> !saturated)
		else $error("degenerate result flagged as saturated");

	// A degenerate triangle gives zero vectors.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && degenerate) |-> (tangent_x == '0 && bitangent_z == '0))
		else $error("degenerate result carries nonzero vectors");

	// The queue is never written while full unless it is read in the same cycle.
	a_q_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_wr || q_rd)
		else $error("triangle queue overrun");

	// The back end never reads an empty queue.
	a_q_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_stat.empty)
		else $error("triangle queue underrun");
`endif

endmodule

// ----- sim/testbench.sv -----
module testbench;
	import ttb_pkg::*;

	localparam int unsigned CW = 16;
	localparam int unsigned UW = 16;
	localparam int unsigned OW = 32;
	localparam int unsigned SHIFT = OW / 2 + (UW - 3) - CW / 2;
	localparam int unsigned RANDOM_CORNERS = 1626;
	localparam int unsigned DRAIN_CYCLES = 800;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [UW-1:0] u;
		logic signed [UW-1:0] v;
	} corner_t;

	typedef struct packed {
		logic signed [OW-1:0] tx;
		logic signed [OW-1:0] ty;
		logic signed [OW-1:0] tz;
		logic signed [OW-1:0] bx;
		logic signed [OW-1:0] by;
		logic signed [OW-1:0] bz;
		logic                 deg;
		logic                 sat;
	} frame_t;

	typedef struct {
		corner_t c;
		bit      typed;
		frame_t  want;
	} row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [CW-1:0] pos_x, pos_y, pos_z;
	logic signed [UW-1:0] tex_u, tex_v;
	logic empty;
	logic pop;
	logic signed [OW-1:0] tangent_x, tangent_y, tangent_z;
	logic signed [OW-1:0] bitangent_x, bitangent_y, bitangent_z;
	logic degenerate;
	logic saturated;

	// Predictor state: corners held for the open triangle.
	int unsigned held_count;
	corner_t held_corner[2];
	frame_t frames_due[$];

	int unsigned errors;
	int unsigned cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_left;
	int unsigned hold_request;

	triangle_tangent_bitangent_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.empty(empty), .pop(pop),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
		.degenerate(degenerate), .saturated(saturated)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Exact quotient scaled to the output format, rounded to nearest with ties
	// away from zero, then clipped to the output range.
	function automatic logic signed [OW-1:0] scaled_quotient(
		input logic signed [127:0] num, input logic signed [127:0] den, inout logic sat);
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		logic [127:0] r;
		logic neg;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		n = n << SHIFT;
		q = n / d;
		r = n % d;
		if ((r << 1) >= d)
			q = q + 1;
		if (neg) begin
			if (q > 128'(OUT_MAX) + 1) begin
				sat = 1'b1;
				return OUT_MIN;
			end
			return -q[OW-1:0];
		end
		if (q > 128'(OUT_MAX)) begin
			sat = 1'b1;
			return OUT_MAX;
		end
		return q[OW-1:0];
	endfunction

	// Takes one corner; returns 1 with the frame when it closes a triangle.
	function automatic bit tangent_frame(input corner_t c, output frame_t f);
		logic signed [127:0] e0[3];
		logic signed [127:0] e1[3];
		logic signed [127:0] pc[3];
		logic signed [127:0] du0, dv0, du1, dv1, det;
		logic sat;
		f = '0;
		if (held_count < 2) begin
			held_corner[held_count] = c;
			held_count++;
			return 1'b0;
		end
		held_count = 0;
		pc[0] = c.x;
		pc[1] = c.y;
		pc[2] = c.z;
		e0[0] = held_corner[1].x - held_corner[0].x;
		e0[1] = held_corner[1].y - held_corner[0].y;
		e0[2] = held_corner[1].z - held_corner[0].z;
		e1[0] = pc[0] - held_corner[0].x;
		e1[1] = pc[1] - held_corner[0].y;
		e1[2] = pc[2] - held_corner[0].z;
		du0 = held_corner[1].u - held_corner[0].u;
		dv0 = held_corner[1].v - held_corner[0].v;
		du1 = c.u - held_corner[0].u;
		dv1 = c.v - held_corner[0].v;
		det = du0 * dv1 - du1 * dv0;
		if (det == 0) begin
			f.deg = 1'b1;
			return 1'b1;
		end
		sat = 1'b0;
		f.tx = scaled_quotient(e0[0] * dv1 - e1[0] * dv0, det, sat);
		f.ty = scaled_quotient(e0[1] * dv1 - e1[1] * dv0, det, sat);
		f.tz = scaled_quotient(e0[2] * dv1 - e1[2] * dv0, det, sat);
		f.bx = scaled_quotient(e1[0] * du0 - e0[0] * du1, det, sat);
		f.by = scaled_quotient(e1[1] * du0 - e0[1] * du1, det, sat);
		f.bz = scaled_quotient(e1[2] * du0 - e0[2] * du1, det, sat);
		f.sat = sat;
		return 1'b1;
	endfunction

	// Offers one corner, waits for its transfer, then records what it causes.
	task automatic send_corner(input corner_t c, input bit typed, input frame_t want);
		frame_t f;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		pos_x <= c.x;
		pos_y <= c.y;
		pos_z <= c.z;
		tex_u <= c.u;
		tex_v <= c.v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (tangent_frame(c, f))
			frames_due = {frames_due, (typed ? want : f)};
	endtask

	function automatic corner_t mk(input int x, input int y, input int z, input int u,
		input int v);
		corner_t c;
		c.x = CW'(x);
		c.y = CW'(y);
		c.z = CW'(z);
		c.u = UW'(u);
		c.v = UW'(v);
		return c;
	endfunction

	function automatic corner_t random_corner(input bit narrow);
		corner_t c;
		c.x = CW'($urandom);
		c.y = CW'($urandom);
		c.z = CW'($urandom);
		c.u = UW'($urandom);
		c.v = UW'($urandom);
		if (narrow) begin
			c.x = $signed(c.x) >>> $urandom_range(14, 4);
			c.u = $signed(c.u) >>> $urandom_range(14, 4);
			c.v = $signed(c.v) >>> $urandom_range(14, 4);
		end
		return c;
	endfunction

	// Result side: check each transfer, then choose pop for the next cycle.
	initial begin
		frame_t got;
		frame_t want;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = {tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
					bitangent_z, degenerate, saturated};
				if (frames_due.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = frames_due.pop_front();
					if (got.tx !== want.tx) report($sformatf("tangent_x %h want %h", got.tx, want.tx));
					if (got.ty !== want.ty) report($sformatf("tangent_y %h want %h", got.ty, want.ty));
					if (got.tz !== want.tz) report($sformatf("tangent_z %h want %h", got.tz, want.tz));
					if (got.bx !== want.bx) report($sformatf("bitangent_x %h want %h", got.bx, want.bx));
					if (got.by !== want.by) report($sformatf("bitangent_y %h want %h", got.by, want.by));
					if (got.bz !== want.bz) report($sformatf("bitangent_z %h want %h", got.bz, want.bz));
					if (got.deg !== want.deg) report($sformatf("degenerate %b want %b", got.deg, want.deg));
					if (got.sat !== want.sat) report($sformatf("saturated %b want %b", got.sat, want.sat));
				end
			end
			pop <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering corners.
	initial begin
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end else if (hold_left != 0) begin
				hold_left--;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout waiting for results");
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		frame_t none;
		corner_t tri_c[3];
		int unsigned total;
		int unsigned phase_len;
		int unsigned w;
		errors = 0;
		cycles = 0;
		held_count = 0;
		hold_request = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		none = '0;
		arst_n = 1'b0;
		push = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		tex_u = '0;
		tex_v = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed triangles; the closing corner carries any typed expectation.
		r.typed = 1'b0;
		r.want = none;
		// All zero: degenerate.
		r.c = mk(0, 0, 0, 0, 0); rows = {rows, r}; rows = {rows, r};
		r.typed = 1'b1; r.want = none; r.want.deg = 1'b1; rows = {rows, r};
		// Equal texture coordinates at the extreme, extreme positions: degenerate.
		r.typed = 1'b0;
		r.c = mk(-32768, 32767, -32768, -32768, -32768); rows = {rows, r};
		r.c = mk(32767, -32768, 32767, -32768, -32768); rows = {rows, r};
		r.typed = 1'b1; r.c = mk(-32768, -32768, 32767, -32768, -32768); rows = {rows, r};
		// Coincident positions with a valid mapping: zero vectors.
		r.typed = 1'b0;
		r.c = mk(100, -200, 300, 0, 0); rows = {rows, r};
		r.c = mk(100, -200, 300, 8192, 0); rows = {rows, r};
		r.typed = 1'b1; r.want = none; r.c = mk(100, -200, 300, 0, 8192); rows = {rows, r};
		// Unit axes: tangent along x and bitangent along y, both 1.0.
		r.typed = 1'b0;
		r.c = mk(0, 0, 0, 0, 0); rows = {rows, r};
		r.c = mk(256, 0, 0, 8192, 0); rows = {rows, r};
		r.typed = 1'b1; r.want = none; r.want.tx = 32'sd65536; r.want.by = 32'sd65536;
		r.c = mk(0, 256, 0, 0, 8192); rows = {rows, r};
		// Smallest determinant with the widest edge: clipped high.
		r.typed = 1'b0;
		r.c = mk(-32768, -32768, -32768, 0, 0); rows = {rows, r};
		r.c = mk(32767, 32767, 32767, 1, 0); rows = {rows, r};
		r.typed = 1'b1; r.want = none;
		r.want.tx = OUT_MAX; r.want.ty = OUT_MAX; r.want.tz = OUT_MAX; r.want.sat = 1'b1;
		r.c = mk(-32768, -32768, -32768, 0, 1); rows = {rows, r};
		// Same, edge reversed: clipped low.
		r.typed = 1'b0;
		r.c = mk(32767, 32767, 32767, 0, 0); rows = {rows, r};
		r.c = mk(-32768, -32768, -32768, 1, 0); rows = {rows, r};
		r.typed = 1'b1; r.want = none;
		r.want.tx = OUT_MIN; r.want.ty = OUT_MIN; r.want.tz = OUT_MIN; r.want.sat = 1'b1;
		r.c = mk(32767, 32767, 32767, 0, 1); rows = {rows, r};
		// Extreme texture coordinates, checked by the predictor.
		r.typed = 1'b0;
		r.c = mk(32767, -32768, 0, 32767, -32768); rows = {rows, r};
		r.c = mk(-32768, 32767, -1, -32768, 32767); rows = {rows, r};
		r.c = mk(1, -1, 32767, 32767, 32767); rows = {rows, r};
		r.c = mk(0, 0, 0, -32768, -32768); rows = {rows, r};
		r.c = mk(-1, 255, -256, -1, 0); rows = {rows, r};
		r.c = mk(12345, -4321, 999, 0, -1); rows = {rows, r};
		foreach (rows[i])
			send_corner(rows[i].c, rows[i].typed, rows[i].want);

		// Random triangles in three idling phases; the receiver stalls long at first.
		total = 0;
		phase_len = RANDOM_CORNERS / 3;
		hold_request = 3000;
		while (total < RANDOM_CORNERS) begin
			if (total < phase_len) begin
				send_idle_pct = 10;
				recv_idle_pct = 88;
			end else if (total < 2 * phase_len) begin
				send_idle_pct = 88;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			w = $urandom_range(99, 0);
			for (int k = 0; k < 3; k++)
				tri_c[k] = random_corner(w < 30);
			if (w >= 90) begin
				// Collinear or repeated texture coordinates make det zero.
				tri_c[1].u = tri_c[0].u;
				tri_c[2].u = tri_c[0].u;
			end else if (w >= 85) begin
				tri_c[2].u = tri_c[1].u;
				tri_c[2].v = tri_c[1].v;
				tri_c[0].u = tri_c[1].u;
			end
			for (int k = 0; k < 3; k++)
				send_corner(tri_c[k], 1'b0, none);
			total += 3;
		end
		push <= 1'b0;

		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
